// ===== rtl/int8_block_scaled_dot_product_macros.svh =====
// Assertion macros used by the block-scaled int8 dot-product accumulator.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef INT8_BLOCK_SCALED_DOT_PRODUCT_MACROS_SVH
`define INT8_BLOCK_SCALED_DOT_PRODUCT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define I8BSDP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("i8bsdp assertion failed");
// next-cycle implication
`define I8BSDP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("i8bsdp assertion failed");
`else
`define I8BSDP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define I8BSDP_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== rtl/i8bsdp_pkg.sv =====
// Types, constants and fp32 helper functions for the int8 block dot product.
// No dependencies.
`default_nettype none

package i8bsdp_pkg;

    localparam int LANES      = 4;
    localparam int LANE_BYTES = 8;
    localparam int PART_W     = 19;   // sum of 8 int8 products
    localparam int ISUM_W     = 21;   // sum of 32 int8 products
    localparam int MAG_W      = 20;

    localparam logic [31:0] F32_QNAN    = 32'h7FC0_0000;
    localparam logic [7:0]  F32_EXP_MAX = 8'hFF;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_NORM,
        CLS_INF,
        CLS_NAN
    } fclass_t;

    // half value as sig * 2^(exp-10), sig[10] set when normal
    typedef struct packed {
        fclass_t            cls;
        logic               sign;
        logic signed [5:0]  exp;
        logic [10:0]        sig;
    } half_t;

    typedef struct packed {
        logic vld;
        logic last;
    } beat_ctl_t;

    function automatic half_t half_unpack(input logic [15:0] h);
        half_t      r;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] k;
        e = h[14:10];
        m = h[9:0];
        k = 4'd0;
        r.sign = h[15];
        r.exp  = 6'sd0;
        r.sig  = {1'b1, m};
        r.cls  = CLS_NORM;
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                r.cls = CLS_ZERO;
                r.sig = 11'd0;
            end else begin
                for (int i = 0; i < 10; i++) begin
                    if (m[i]) k = 4'(10 - i);
                end
                r.sig = 11'({1'b0, m} << k);
                r.exp = -6'sd14 - $signed({2'b00, k});
            end
        end else if (e == 5'h1F) begin
            r.cls = (m != 10'd0) ? CLS_NAN : CLS_INF;
        end else begin
            r.exp = $signed({1'b0, e}) - 6'sd15;
        end
        return r;
    endfunction

    function automatic logic [5:0] lead_zeros48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    // m[47] set, value m * 2^(e-47); round to nearest even into fp32 bits
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [9:0] e,
                                               input logic [47:0] m);
        logic signed [10:0] eb;
        logic [10:0]        sh;
        logic [47:0]        den;
        logic               stk;
        logic               ovf;
        logic               g;
        logic               st;
        logic               inc;
        logic [31:0]        r;
        eb  = {e[9], e} + 11'sd127;
        ovf = 1'b0;
        stk = 1'b0;
        den = m;
        if (eb >= 11'sd1) begin
            ovf = (eb >= 11'sd255);
            r   = {1'b0, eb[7:0], m[46:24]};
        end else begin
            sh = 11'(11'sd1 - eb);
            if (sh >= 11'd48) begin
                den = 48'd0;
                stk = |m;
            end else begin
                den = m >> sh[5:0];
                stk = |(m & ((48'd1 << sh[5:0]) - 48'd1));
            end
            r = {9'd0, den[46:24]};
        end
        g   = den[23];
        st  = (|den[22:0]) | stk;
        inc = g & (st | r[0]);
        r   = r + 32'(inc);
        if (ovf || r[30:23] == F32_EXP_MAX) begin
            r = {sign, F32_EXP_MAX, 23'd0};
        end else begin
            r = {sign, r[30:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/i8bsdp_lane.sv =====
// One dot-product lane: eight signed byte pairs multiplied and summed.
// Depends on i8bsdp_pkg.
`default_nettype none

module i8bsdp_lane
    import i8bsdp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      load,
    input  wire logic [8*LANE_BYTES-1:0]   x_word,
    input  wire logic [8*LANE_BYTES-1:0]   y_word,
    output logic signed [PART_W-1:0]       part
);

    logic signed [PART_W-1:0] part_reg;
    logic signed [PART_W-1:0] part_next;

    always_comb
    begin
        logic signed [15:0] prod;
        part_next = '0;
        for (int i = 0; i < LANE_BYTES; i++) begin
            prod      = $signed(x_word[8*i +: 8]) * $signed(y_word[8*i +: 8]);
            part_next = part_next + PART_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) part_reg <= part_next;
    end

    assign part = part_reg;

endmodule

`default_nettype wire

// ===== rtl/i8bsdp_scale.sv =====
// Merge of the lane sums and scaling: half widening, scale product,
// product with the integer sum, normalize and round to fp32. Uses i8bsdp_pkg.
`default_nettype none

module i8bsdp_scale
    import i8bsdp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     last,
    input  wire logic [15:0]              x_scale,
    input  wire logic [15:0]              y_scale,
    input  wire logic signed [PART_W-1:0] parts [LANES],
    output beat_ctl_t                     p_ctl,
    output logic [31:0]                   p_bits,
    output logic                          busy
);

    logic [4:0] vld_reg;
    logic [4:0] last_reg;

    // stage 1: widened scales
    half_t xh_reg;
    half_t yh_reg;
    // stage 2: integer sum and scale product
    logic signed [ISUM_W-1:0] isum_reg;
    logic [21:0]              dsig_reg;
    logic signed [6:0]        dexp_reg;
    logic                     dsign_reg;
    fclass_t                  dcls_reg;
    // stage 3: full product
    logic [41:0]              prod_reg;
    logic signed [6:0]        pexp_reg;
    logic                     psign_reg;
    fclass_t                  pcls_reg;
    // stage 4: leading zero count
    logic [41:0]              nprod_reg;
    logic [5:0]               lz_reg;
    logic signed [6:0]        nexp_reg;
    logic                     nsign_reg;
    fclass_t                  ncls_reg;
    // stage 5
    logic [31:0]              p_bits_reg;

    logic signed [ISUM_W-1:0] isum_next;
    fclass_t                  dcls_next;
    fclass_t                  pcls_next;
    logic [MAG_W-1:0]         mag;
    logic signed [9:0]        rexp;
    logic [47:0]              rmant;
    logic [31:0]              p_bits_next;

    always_comb
    begin
        isum_next = '0;
        for (int i = 0; i < LANES; i++) begin
            isum_next = isum_next + ISUM_W'(parts[i]);
        end
    end

    always_comb
    begin
        if (xh_reg.cls == CLS_NAN || yh_reg.cls == CLS_NAN
            || (xh_reg.cls == CLS_INF && yh_reg.cls == CLS_ZERO)
            || (xh_reg.cls == CLS_ZERO && yh_reg.cls == CLS_INF)) begin
            dcls_next = CLS_NAN;
        end else if (xh_reg.cls == CLS_INF || yh_reg.cls == CLS_INF) begin
            dcls_next = CLS_INF;
        end else if (xh_reg.cls == CLS_ZERO || yh_reg.cls == CLS_ZERO) begin
            dcls_next = CLS_ZERO;
        end else begin
            dcls_next = CLS_NORM;
        end
    end

    always_comb
    begin
        mag = isum_reg[ISUM_W-1] ? MAG_W'(-isum_reg) : MAG_W'(isum_reg);
        if (dcls_reg == CLS_NAN) begin
            pcls_next = CLS_NAN;
        end else if (dcls_reg == CLS_INF) begin
            pcls_next = (isum_reg == '0) ? CLS_NAN : CLS_INF;
        end else if (dcls_reg == CLS_ZERO || isum_reg == '0) begin
            pcls_next = CLS_ZERO;
        end else begin
            pcls_next = CLS_NORM;
        end
    end

    // value = prod * 2^(exp-20); msb of prod sits at bit 41-lz
    always_comb
    begin
        rexp  = {{3{nexp_reg[6]}}, nexp_reg} + 10'sd21 - $signed({4'd0, lz_reg});
        rmant = {nprod_reg, 6'd0} << lz_reg;
        case (ncls_reg)
            CLS_NAN:  p_bits_next = F32_QNAN;
            CLS_INF:  p_bits_next = {nsign_reg, F32_EXP_MAX, 23'd0};
            CLS_ZERO: p_bits_next = {nsign_reg, 31'd0};
            default:  p_bits_next = round_pack(nsign_reg, rexp, rmant);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg  <= '0;
            last_reg <= '0;
        end else begin
            vld_reg  <= {vld_reg[3:0], start};
            last_reg <= {last_reg[3:0], last};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            xh_reg <= half_unpack(x_scale);
            yh_reg <= half_unpack(y_scale);
        end
        if (vld_reg[0]) begin
            isum_reg  <= isum_next;
            dsig_reg  <= 22'(xh_reg.sig) * 22'(yh_reg.sig);
            dexp_reg  <= 7'(xh_reg.exp) + 7'(yh_reg.exp);
            dsign_reg <= xh_reg.sign ^ yh_reg.sign;
            dcls_reg  <= dcls_next;
        end
        if (vld_reg[1]) begin
            prod_reg  <= 42'(dsig_reg) * 42'(mag);
            pexp_reg  <= dexp_reg;
            psign_reg <= dsign_reg ^ isum_reg[ISUM_W-1];
            pcls_reg  <= pcls_next;
        end
        if (vld_reg[2]) begin
            nprod_reg <= prod_reg;
            lz_reg    <= lead_zeros48({prod_reg, 6'd0});
            nexp_reg  <= pexp_reg;
            nsign_reg <= psign_reg;
            ncls_reg  <= pcls_reg;
        end
        if (vld_reg[3]) begin
            p_bits_reg <= p_bits_next;
        end
    end

    assign p_ctl.vld  = vld_reg[4];
    assign p_ctl.last = last_reg[4];
    assign p_bits     = p_bits_reg;
    assign busy       = |vld_reg;

endmodule

`default_nettype wire

// ===== rtl/i8bsdp_acc.sv =====
// fp32 accumulator: align, add, normalize, round; emits the sum on the
// last block and clears. Uses i8bsdp_pkg and the assertion macro header.
`default_nettype none

`include "int8_block_scaled_dot_product_macros.svh"

module i8bsdp_acc
    import i8bsdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire beat_ctl_t   p_ctl,
    input  wire logic [31:0] p_bits,
    output logic             busy,
    output logic             tvalid,
    input  wire logic        tready,
    output logic [31:0]      tdata
);

    logic [3:0]  vld_reg;
    logic [3:0]  vld_next;
    logic [3:0]  last_reg;
    logic [31:0] acc_reg;
    logic        out_vld_reg;
    logic [31:0] out_data_reg;

    // align stage
    logic        sgn_reg;
    logic        sub_reg;
    logic [7:0]  eff_reg;
    logic [26:0] big_reg;
    logic [26:0] small_reg;
    logic        snan_reg;
    logic        sinf_reg;
    logic        isgn_reg;
    // add stage
    logic [27:0] sum_reg;
    // count stage
    logic [27:0] nsum_reg;
    logic [5:0]  lz_reg;

    // align logic
    logic        nan_a, nan_b, inf_a, inf_b, a_big;
    logic [31:0] big_op, small_op;
    logic [7:0]  eff_big, eff_small, diff;
    logic [26:0] big_ext, small_ext, small_al;

    logic signed [9:0] rexp;
    logic [31:0]       res;
    logic              done;

    always_comb
    begin
        nan_a = (acc_reg[30:23] == F32_EXP_MAX) && (acc_reg[22:0] != '0);
        nan_b = (p_bits[30:23] == F32_EXP_MAX) && (p_bits[22:0] != '0);
        inf_a = (acc_reg[30:23] == F32_EXP_MAX) && (acc_reg[22:0] == '0);
        inf_b = (p_bits[30:23] == F32_EXP_MAX) && (p_bits[22:0] == '0);
        a_big = acc_reg[30:0] >= p_bits[30:0];
        big_op   = a_big ? acc_reg : p_bits;
        small_op = a_big ? p_bits : acc_reg;
        eff_big   = (big_op[30:23] == '0) ? 8'd1 : big_op[30:23];
        eff_small = (small_op[30:23] == '0) ? 8'd1 : small_op[30:23];
        diff      = eff_big - eff_small;
        big_ext   = {big_op[30:23] != '0, big_op[22:0], 3'd0};
        small_ext = {small_op[30:23] != '0, small_op[22:0], 3'd0};
        if (diff >= 8'd27) begin
            small_al = {26'd0, |small_ext};
        end else begin
            small_al = (small_ext >> diff[4:0])
                     | 27'(|(small_ext & ((27'd1 << diff[4:0]) - 27'd1)));
        end
    end

    // hidden bit of the aligned word sits at bit 26
    always_comb
    begin
        rexp = $signed({2'd0, eff_reg}) - 10'sd126 - $signed({4'd0, lz_reg});
        if (snan_reg) begin
            res = F32_QNAN;
        end else if (sinf_reg) begin
            res = {isgn_reg, F32_EXP_MAX, 23'd0};
        end else if (nsum_reg == '0) begin
            res = {sub_reg ? 1'b0 : sgn_reg, 31'd0};
        end else begin
            res = round_pack(sgn_reg, rexp, {nsum_reg, 20'd0} << lz_reg);
        end
    end

    // a last beat waits here while the previous result is still unread
    assign done = vld_reg[3] && !(last_reg[3] && out_vld_reg && !tready);

    always_comb
    begin
        vld_next[0] = p_ctl.vld;
        vld_next[1] = vld_reg[0];
        vld_next[2] = vld_reg[1];
        vld_next[3] = vld_reg[2] || (vld_reg[3] && !done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg     <= '0;
            last_reg    <= '0;
            acc_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            last_reg[2:0] <= {last_reg[1:0], p_ctl.last};
            if (!vld_reg[3] || done) last_reg[3] <= last_reg[2];
            if (done) begin
                acc_reg <= last_reg[3] ? 32'd0 : res;
            end
            if (done && last_reg[3]) begin
                out_vld_reg <= 1'b1;
            end else if (tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ctl.vld) begin
            sgn_reg   <= big_op[31];
            sub_reg   <= acc_reg[31] ^ p_bits[31];
            eff_reg   <= eff_big;
            big_reg   <= big_ext;
            small_reg <= small_al;
            snan_reg  <= nan_a || nan_b || (inf_a && inf_b && (acc_reg[31] != p_bits[31]));
            sinf_reg  <= inf_a || inf_b;
            isgn_reg  <= inf_a ? acc_reg[31] : p_bits[31];
        end
        if (vld_reg[0]) begin
            sum_reg <= sub_reg ? ({1'b0, big_reg} - {1'b0, small_reg})
                               : ({1'b0, big_reg} + {1'b0, small_reg});
        end
        if (vld_reg[1]) begin
            nsum_reg <= sum_reg;
            lz_reg   <= lead_zeros48({sum_reg, 20'd0});
        end
        if (done && last_reg[3]) begin
            out_data_reg <= res;
        end
    end

    assign busy   = |vld_reg;
    assign tvalid = out_vld_reg;
    assign tdata  = out_data_reg;

    `I8BSDP_ASSERT_IMP(a_one_in_flight, clk, rst_n, 1'b1, $onehot0(vld_reg))
    `I8BSDP_ASSERT_NXT(a_clear_after_last, clk, rst_n, done && last_reg[3], acc_reg == 32'd0)
    `I8BSDP_ASSERT_IMP(a_nan_canonical, clk, rst_n, out_vld_reg && out_data_reg[30:23] == F32_EXP_MAX && out_data_reg[22:0] != 23'd0, out_data_reg == F32_QNAN)

endmodule

`default_nettype wire

// ===== rtl/int8_block_scaled_dot_product.sv =====
// Block-scaled int8 dot product, top level: four byte lanes, scaling
// unit and fp32 accumulator. Uses i8bsdp_pkg, i8bsdp_lane, i8bsdp_scale, i8bsdp_acc.
//
// Usage:
//   Slave stream takes one block pair per beat: 32 x bytes, 32 y bytes and
//   two fp16 scales in tdata, tlast marking the final block of the vectors.
//   Four lanes each multiply and sum eight byte pairs; the merge stage adds
//   the lane sums, the scales are widened and multiplied exactly, the
//   product with the integer sum is rounded to fp32 and added (round to
//   nearest even) to the running sum.
//   Master stream carries one fp32 beat per tlast beat: the sum including
//   that block; the running sum then restarts at +0. NaNs come out as
//   0x7FC00000.
//   The block holds one item at a time: a new beat is accepted only once
//   the nine-stage path through the fp32 accumulator loop is empty.
//   A stalled master holds a finished sum in the output register while the
//   next item is accepted; a further last beat waits in the round stage.
//   Reset clears all stage valids and the output valid, and the sum to +0.
`default_nettype none

module int8_block_scaled_dot_product
    import i8bsdp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // x_bytes_a, x_bytes_b, x_bytes_c, x_bytes_d, y_bytes_a, y_bytes_b,
    // y_bytes_c, y_bytes_d, x_scale, y_scale
    input  wire logic [543:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // dot_result
    output logic [31:0]       m_axis_tdata
);

    logic                     accept;
    logic                     scale_busy;
    logic                     acc_busy;
    logic signed [PART_W-1:0] parts [LANES];
    beat_ctl_t                p_ctl;
    logic [31:0]              p_bits;

    assign s_axis_tready = !scale_busy && !acc_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        i8bsdp_lane u_lane (
            .clk    (clk),
            .load   (accept),
            .x_word (s_axis_tdata[64*g +: 64]),
            .y_word (s_axis_tdata[64*(g+LANES) +: 64]),
            .part   (parts[g])
        );
    end

    i8bsdp_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .last    (s_axis_tlast),
        .x_scale (s_axis_tdata[527:512]),
        .y_scale (s_axis_tdata[543:528]),
        .parts   (parts),
        .p_ctl   (p_ctl),
        .p_bits  (p_bits),
        .busy    (scale_busy)
    );

    i8bsdp_acc u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .p_ctl  (p_ctl),
        .p_bits (p_bits),
        .busy   (acc_busy),
        .tvalid (m_axis_tvalid),
        .tready (m_axis_tready),
        .tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
